@@ rtl/euvf_pkg.sv @@
// euvf_pkg: shared types and constants for the encoder unwrap and velocity filter
// used by the controller, datapath and top level; no dependencies
package euvf_pkg;

    localparam int NBANK      = 3;
    localparam int BANK_W     = 2;
    localparam int ANGLE_W    = 14;
    localparam int TIME_W     = 32;
    localparam int UNW_W      = 30;
    localparam int POS_W      = 38;
    localparam int VEL_W      = 40;
    localparam int FILT_W     = 40;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int PROD_W     = 62;
    localparam int DIV_STEPS  = 62;
    localparam int ACC_W      = 60;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POS_RETAIN_FAST = 3'd0,
        REG_POS_RETAIN_MID  = 3'd1,
        REG_POS_RETAIN_SLOW = 3'd2,
        REG_VEL_RETAIN_FAST = 3'd3,
        REG_VEL_RETAIN_MID  = 3'd4,
        REG_VEL_RETAIN_SLOW = 3'd5,
        REG_TICKS_PER_SEC   = 3'd6
    } reg_idx_t;

    localparam logic [GAIN_W-1:0] POS_RETAIN_FAST_RST = 16'd58982;
    localparam logic [GAIN_W-1:0] POS_RETAIN_MID_RST  = 16'd64880;
    localparam logic [GAIN_W-1:0] POS_RETAIN_SLOW_RST = 16'd65470;
    localparam logic [GAIN_W-1:0] VEL_RETAIN_FAST_RST = 16'd64880;
    localparam logic [GAIN_W-1:0] VEL_RETAIN_MID_RST  = 16'd65470;
    localparam logic [GAIN_W-1:0] VEL_RETAIN_SLOW_RST = 16'd65529;
    localparam logic [TIME_W-1:0] TPS_RST             = 32'd1000000;
    localparam int                TURN_LIMIT          = 32767;

    typedef struct packed {
        logic              capture;
        logic              turn;
        logic              unwrap;
        logic              delta;
        logic              mul_lo;
        logic              mul_hi;
        logic              div_step;
        logic              vel_fin;
        logic              filt_mul;
        logic              filt_acc;
        logic              filt_wr;
        logic              seed;
        logic              load_out;
        logic [BANK_W-1:0] bank;
        logic              is_vel;
    } cmd_t;

    typedef struct packed {
        logic seeded;
        logic out_free;
    } sts_t;

endpackage

@@ rtl/euvf_if.sv @@
// euvf_if: valid/ready channel interfaces for samples, results and register writes
// depends on nothing; widths follow the field list of the block
interface euvf_in_if;
    logic        valid;
    logic        ready;
    logic [13:0] angle_sample;
    logic [31:0] timestamp;
    modport source (output valid, angle_sample, timestamp, input ready);
    modport sink   (input valid, angle_sample, timestamp, output ready);
endinterface

interface euvf_out_if;
    logic               valid;
    logic               ready;
    logic signed [29:0] unwrapped_position;
    logic signed [37:0] position_fast;
    logic signed [37:0] position_mid;
    logic signed [37:0] position_slow;
    logic signed [39:0] velocity_fast;
    logic signed [39:0] velocity_mid;
    logic signed [39:0] velocity_slow;
    modport source (output valid, unwrapped_position, position_fast, position_mid,
                    position_slow, velocity_fast, velocity_mid, velocity_slow,
                    input ready);
    modport sink   (input valid, unwrapped_position, position_fast, position_mid,
                    position_slow, velocity_fast, velocity_mid, velocity_slow,
                    output ready);
endinterface

interface euvf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/euvf_ctrl.sv @@
// euvf_ctrl: sequencer for unwrap, multiply, divide and filter steps
// depends on euvf_pkg; drives the datapath through cmd_t and reads sts_t
module euvf_ctrl #(
    parameter int NB_USED = 3
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  euvf_pkg::sts_t  sts,
    output euvf_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_TURN, S_UNW, S_DELTA, S_MUL_LO, S_MUL_HI, S_DIV, S_VEL,
        S_F_MUL, S_F_ACC, S_F_WR, S_SEED, S_OUT
    } state_t;

    localparam logic [euvf_pkg::BANK_W-1:0] LAST_BANK = euvf_pkg::BANK_W'(NB_USED - 1);
    localparam logic [5:0] LAST_STEP = 6'(euvf_pkg::DIV_STEPS - 1);

    state_t                        state_reg;
    logic [5:0]                    cnt_reg;
    logic [euvf_pkg::BANK_W-1:0]   bank_reg;
    logic                          is_vel_reg;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd          = '0;
        cmd.bank     = bank_reg;
        cmd.is_vel   = is_vel_reg;
        cmd.capture  = (state_reg == S_IDLE) && in_valid;
        cmd.turn     = (state_reg == S_TURN);
        cmd.unwrap   = (state_reg == S_UNW);
        cmd.delta    = (state_reg == S_DELTA);
        cmd.mul_lo   = (state_reg == S_MUL_LO);
        cmd.mul_hi   = (state_reg == S_MUL_HI);
        cmd.div_step = (state_reg == S_DIV);
        cmd.vel_fin  = (state_reg == S_VEL);
        cmd.filt_mul = (state_reg == S_F_MUL);
        cmd.filt_acc = (state_reg == S_F_ACC);
        cmd.filt_wr  = (state_reg == S_F_WR);
        cmd.seed     = (state_reg == S_SEED);
        cmd.load_out = (state_reg == S_OUT) && sts.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            bank_reg   <= '0;
            is_vel_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= sts.seeded ? S_TURN : S_UNW;
                end
                S_TURN:   state_reg <= S_UNW;
                S_UNW:    state_reg <= sts.seeded ? S_DELTA : S_SEED;
                S_DELTA:  state_reg <= S_MUL_LO;
                S_MUL_LO: state_reg <= S_MUL_HI;
                S_MUL_HI:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == LAST_STEP)
                        state_reg <= S_VEL;
                end
                S_VEL:
                begin
                    bank_reg   <= '0;
                    is_vel_reg <= 1'b0;
                    state_reg  <= S_F_MUL;
                end
                S_F_MUL:  state_reg <= S_F_ACC;
                S_F_ACC:  state_reg <= S_F_WR;
                S_F_WR:
                begin
                    // position banks first, then velocity banks
                    if (bank_reg != LAST_BANK)
                    begin
                        bank_reg  <= bank_reg + 1'b1;
                        state_reg <= S_F_MUL;
                    end
                    else if (!is_vel_reg)
                    begin
                        bank_reg   <= '0;
                        is_vel_reg <= 1'b1;
                        state_reg  <= S_F_MUL;
                    end
                    else
                        state_reg <= S_OUT;
                end
                S_SEED:   state_reg <= S_OUT;
                S_OUT:
                begin
                    if (sts.out_free)
                        state_reg <= S_IDLE;
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/euvf_datapath.sv @@
// euvf_datapath: unwrap state, velocity multiply and restoring divide, filter bank
// depends on euvf_pkg; steered by cmd_t from euvf_ctrl, holds config and result registers
module euvf_datapath #(
    parameter int COUNTS_PER_TURN = 16384,
    parameter int NB_USED         = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  euvf_pkg::cmd_t       cmd,
    output euvf_pkg::sts_t       sts,
    input  logic [13:0]          angle_sample,
    input  logic [31:0]          timestamp,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [29:0]   out_unw,
    output logic signed [37:0]   out_pos [euvf_pkg::NBANK],
    output logic signed [39:0]   out_vel [euvf_pkg::NBANK]
);

    localparam int          WRAP_THR = (COUNTS_PER_TURN * 125) / 256;
    localparam logic [16:0] CPT_W    = 17'(COUNTS_PER_TURN);

    logic [15:0]        pos_retain_reg [euvf_pkg::NBANK];
    logic [15:0]        vel_retain_reg [euvf_pkg::NBANK];
    logic [31:0]        tps_reg;

    logic               seeded_reg;
    logic [13:0]        prev_angle_reg;
    logic signed [15:0] turn_reg;
    logic [31:0]        prev_time_reg;
    logic signed [29:0] prev_unw_reg;
    logic signed [39:0] fpos_reg [euvf_pkg::NBANK];
    logic signed [39:0] fvel_reg [euvf_pkg::NBANK];

    logic [13:0]        angle_reg;
    logic [31:0]        ts_reg;
    logic signed [29:0] unw_reg;
    logic [31:0]        dt_reg;
    logic [30:0]        mag_reg;
    logic               neg_reg;
    logic [61:0]        prod_reg;
    logic [31:0]        rem_reg;
    logic signed [31:0] vel_reg;
    logic signed [59:0] acc_reg;
    logic               out_valid_reg;

    logic signed [14:0] d_ang;
    logic signed [31:0] d_ext;
    logic signed [32:0] turn_prod;
    logic [31:0]        dt_raw;
    logic signed [30:0] delta;
    logic [32:0]        rem_sh;
    logic               ge;
    logic [15:0]        g;
    logic [16:0]        gc;
    logic signed [39:0] f_sel;
    logic signed [39:0] x_sel;

    assign sts.seeded   = seeded_reg;
    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;

    always_comb
    begin
        d_ang     = $signed({1'b0, angle_reg}) - $signed({1'b0, prev_angle_reg});
        d_ext     = 32'(d_ang);
        turn_prod = $signed(turn_reg) * $signed({1'b0, CPT_W});
        dt_raw    = ts_reg - prev_time_reg;
        delta     = 31'(unw_reg) - 31'(prev_unw_reg);
        rem_sh    = {rem_reg, prod_reg[61]};
        ge        = rem_sh >= {1'b0, dt_reg};
        g         = cmd.is_vel ? vel_retain_reg[cmd.bank] : pos_retain_reg[cmd.bank];
        gc        = 17'(17'h10000 - {1'b0, g});
        f_sel     = cmd.is_vel ? fvel_reg[cmd.bank] : fpos_reg[cmd.bank];
        x_sel     = cmd.is_vel ? {vel_reg, 8'b0} : {{2{unw_reg[29]}}, unw_reg, 8'b0};
    end

    // config and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_retain_reg[0] <= euvf_pkg::POS_RETAIN_FAST_RST;
            pos_retain_reg[1] <= euvf_pkg::POS_RETAIN_MID_RST;
            pos_retain_reg[2] <= euvf_pkg::POS_RETAIN_SLOW_RST;
            vel_retain_reg[0] <= euvf_pkg::VEL_RETAIN_FAST_RST;
            vel_retain_reg[1] <= euvf_pkg::VEL_RETAIN_MID_RST;
            vel_retain_reg[2] <= euvf_pkg::VEL_RETAIN_SLOW_RST;
            tps_reg           <= euvf_pkg::TPS_RST;
            seeded_reg        <= 1'b0;
            prev_angle_reg    <= '0;
            turn_reg          <= '0;
            prev_time_reg     <= '0;
            prev_unw_reg      <= '0;
            out_valid_reg     <= 1'b0;
            for (int i = 0; i < euvf_pkg::NBANK; i++)
            begin
                fpos_reg[i] <= '0;
                fvel_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (euvf_pkg::reg_idx_t'(cfg_index))
                    euvf_pkg::REG_POS_RETAIN_FAST: pos_retain_reg[0] <= cfg_data[15:0];
                    euvf_pkg::REG_POS_RETAIN_MID:  pos_retain_reg[1] <= cfg_data[15:0];
                    euvf_pkg::REG_POS_RETAIN_SLOW: pos_retain_reg[2] <= cfg_data[15:0];
                    euvf_pkg::REG_VEL_RETAIN_FAST: vel_retain_reg[0] <= cfg_data[15:0];
                    euvf_pkg::REG_VEL_RETAIN_MID:  vel_retain_reg[1] <= cfg_data[15:0];
                    euvf_pkg::REG_VEL_RETAIN_SLOW: vel_retain_reg[2] <= cfg_data[15:0];
                    euvf_pkg::REG_TICKS_PER_SEC:   tps_reg           <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.turn)
            begin
                if (d_ext > WRAP_THR)
                begin
                    if (turn_reg > -16'sd32767)
                        turn_reg <= turn_reg - 16'sd1;
                end
                else if (d_ext < -WRAP_THR)
                begin
                    if (turn_reg < 16'sd32767)
                        turn_reg <= turn_reg + 16'sd1;
                end
            end
            if (cmd.filt_wr)
            begin
                if (cmd.is_vel)
                    fvel_reg[cmd.bank] <= acc_reg[55:16];
                else
                    fpos_reg[cmd.bank] <= acc_reg[55:16];
            end
            if (cmd.seed)
            begin
                seeded_reg <= 1'b1;
                for (int i = 0; i < euvf_pkg::NBANK; i++)
                begin
                    fpos_reg[i] <= (i < NB_USED) ? $signed({18'b0, angle_reg, 8'b0}) : '0;
                    fvel_reg[i] <= '0;
                end
            end
            if (cmd.load_out)
            begin
                prev_angle_reg <= angle_reg;
                prev_time_reg  <= ts_reg;
                prev_unw_reg   <= unw_reg;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            angle_reg <= angle_sample;
            ts_reg    <= timestamp;
        end
        if (cmd.unwrap)
        begin
            unw_reg <= 30'(turn_prod + $signed({19'b0, angle_reg}));
            dt_reg  <= (dt_raw == '0) ? 32'd1 : dt_raw;
        end
        if (cmd.delta)
        begin
            neg_reg <= delta[30];
            mag_reg <= delta[30] ? 31'(-delta) : 31'(delta);
        end
        if (cmd.mul_lo)
        begin
            prod_reg <= 62'(mag_reg) * 62'(tps_reg[15:0]);
            rem_reg  <= '0;
        end
        if (cmd.mul_hi)
            prod_reg <= prod_reg + ((62'(mag_reg) * 62'(tps_reg[31:16])) << 16);
        if (cmd.div_step)
        begin
            rem_reg  <= ge ? 32'(rem_sh - {1'b0, dt_reg}) : rem_sh[31:0];
            prod_reg <= {prod_reg[60:0], ge};
        end
        if (cmd.vel_fin)
        begin
            if (!neg_reg)
                vel_reg <= (|prod_reg[61:31]) ? 32'sh7fffffff : $signed(prod_reg[31:0]);
            else if ((|prod_reg[61:32]) || (prod_reg[31] && (|prod_reg[30:0])))
                vel_reg <= 32'sh80000000;
            else
                vel_reg <= $signed(-prod_reg[31:0]);
        end
        if (cmd.filt_mul)
            acc_reg <= $signed({1'b0, g}) * f_sel;
        if (cmd.filt_acc)
            acc_reg <= acc_reg + $signed({1'b0, gc}) * x_sel + 60'sd32768;
        if (cmd.load_out)
        begin
            out_unw <= unw_reg;
            for (int i = 0; i < euvf_pkg::NBANK; i++)
            begin
                out_pos[i] <= (i < NB_USED) ? fpos_reg[i][37:0] : '0;
                out_vel[i] <= (i < NB_USED) ? fvel_reg[i] : '0;
            end
        end
    end

endmodule

@@ rtl/encoder_unwrap_velocity_filter.sv @@
// encoder_unwrap_velocity_filter: top level joining controller and datapath
// depends on euvf_pkg, euvf_if, euvf_ctrl, euvf_datapath
//
//   channel   dir   content
//   sample    in    angle_sample, timestamp
//   result    out   unwrapped_position, position_*, velocity_*
//   cfg       in    index, data (register write, always ready)
//
// a first sample runs capture, unwrap, seed and output load; later samples run turn,
// unwrap, delta, multiply low and high, the bit-serial divider, velocity and each
// bank's position and velocity filters, then output load; requests wait for idle
// a waiting result does not block the next request; the block holds a finished
// result only when the previous one is still not taken
// reset clears the turn count, the seed flag, the filters and loads default gains
module encoder_unwrap_velocity_filter #(
    parameter int COUNTS_PER_TURN = 16384,
    parameter int FILTER_BANKS    = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    euvf_in_if.sink           sample,
    euvf_out_if.source        result,
    euvf_cfg_if.sink          cfg
);

    localparam int NB_USED = (FILTER_BANKS < euvf_pkg::NBANK) ? FILTER_BANKS
                                                              : euvf_pkg::NBANK;

    euvf_pkg::cmd_t     cmd;
    euvf_pkg::sts_t     sts;
    logic signed [37:0] pos [euvf_pkg::NBANK];
    logic signed [39:0] vel [euvf_pkg::NBANK];

    assign cfg.ready = 1'b1;

    euvf_ctrl #(
        .NB_USED (NB_USED)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (sample.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    euvf_datapath #(
        .COUNTS_PER_TURN (COUNTS_PER_TURN),
        .NB_USED         (NB_USED)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .angle_sample (sample.angle_sample),
        .timestamp    (sample.timestamp),
        .cfg_we       (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .out_valid    (result.valid),
        .out_ready    (result.ready),
        .out_unw      (result.unwrapped_position),
        .out_pos      (pos),
        .out_vel      (vel)
    );

    assign result.position_fast = pos[0];
    assign result.position_mid  = pos[1];
    assign result.position_slow = pos[2];
    assign result.velocity_fast = vel[0];
    assign result.velocity_mid  = vel[1];
    assign result.velocity_slow = vel[2];

endmodule

@@ sim/encoder_unwrap_velocity_filter_test.sv @@
// encoder_unwrap_velocity_filter_test: checks angle unwrap, velocity and filter banks
// against a behavioral predictor; depends on euvf_pkg, euvf_if and the block's rtl
module encoder_unwrap_velocity_filter_test;

    localparam int RUN_LIMIT  = 1000000;
    localparam int WRAP_LIMIT = 8000;

    typedef struct {
        logic [29:0] unw;
        logic [37:0] pos [3];
        logic [39:0] vel [3];
    } sample_out_t;

    typedef struct {
        logic [13:0] angle;
        logic [31:0] ts;
        bit          typed;
        logic [29:0] unw;
        logic [37:0] pos;
        logic [39:0] vel;
    } row_t;

    logic clk;
    logic rst_n;
    euvf_in_if  sample ();
    euvf_out_if result ();
    euvf_cfg_if cfg ();

    encoder_unwrap_velocity_filter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    // predictor state
    bit             seeded_q;
    logic [13:0]    last_angle;
    int             turns;
    logic [31:0]    last_time;
    longint         last_unw;
    longint         pos_filt [3];
    longint         vel_filt [3];
    logic [15:0]    pos_retain [3];
    logic [15:0]    vel_retain [3];
    logic [31:0]    tick_rate;

    sample_out_t    pending_results [$];
    int             errors;
    int             cycles;
    int             taken;
    int             sent;
    bit             hold_off;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT)
        begin
            $display("run hit the cycle limit with %0d results pending",
                     pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic longint to_signed(longint v, int w);
        longint m;
        m = (longint'(1) << w) - 1;
        v = v & m;
        if (v[w-1])
            v = v - (longint'(1) << w);
        return v;
    endfunction

    function automatic longint smooth(longint f, longint x, logic [15:0] g);
        longint s;
        s = longint'(g) * f + (65536 - longint'(g)) * x + 32768;
        return s >>> 16;
    endfunction

    function automatic sample_out_t predict_sample(logic [13:0] angle, logic [31:0] ts);
        sample_out_t r;
        int          d;
        logic [31:0] dt;
        longint      unw;
        longint      v;
        logic signed [95:0] prod;
        d = int'(angle) - int'(last_angle);
        if (seeded_q)
        begin
            if (d > WRAP_LIMIT && turns > -euvf_pkg::TURN_LIMIT)
                turns--;
            else if (d < -WRAP_LIMIT && turns < euvf_pkg::TURN_LIMIT)
                turns++;
        end
        unw = to_signed(longint'(angle) + longint'(turns) * 16384, 30);
        if (seeded_q)
        begin
            dt = ts - last_time;
            if (dt == 0)
                dt = 1;
            prod = 96'(signed'(unw - last_unw)) * $signed({1'b0, tick_rate});
            prod = prod / $signed({1'b0, dt});
            if (prod > 96'sd2147483647)
                v = 64'sd2147483647;
            else if (prod < -96'sd2147483648)
                v = -64'sd2147483648;
            else
                v = longint'(prod);
            for (int i = 0; i < 3; i++)
            begin
                pos_filt[i] = smooth(pos_filt[i], unw * 256, pos_retain[i]);
                vel_filt[i] = smooth(vel_filt[i], v * 256, vel_retain[i]);
            end
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos_filt[i] = longint'(angle) * 256;
                vel_filt[i] = 0;
            end
            seeded_q = 1'b1;
        end
        last_angle = angle;
        last_time  = ts;
        last_unw   = unw;
        r.unw = unw[29:0];
        for (int i = 0; i < 3; i++)
        begin
            r.pos[i] = pos_filt[i][37:0];
            r.vel[i] = vel_filt[i][39:0];
        end
        return r;
    endfunction

    // result checking
    always @(posedge clk)
    begin
        sample_out_t e;
        if (rst_n && result.valid && result.ready)
        begin
            taken <= taken + 1;
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected");
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (result.unwrapped_position !== e.unw)
                begin
                    $error("unwrapped_position exp %0d got %0d", $signed(e.unw),
                           result.unwrapped_position);
                    errors++;
                end
                if (result.position_fast !== e.pos[0])
                begin
                    $error("position_fast exp %0d got %0d", $signed(e.pos[0]),
                           result.position_fast);
                    errors++;
                end
                if (result.position_mid !== e.pos[1])
                begin
                    $error("position_mid exp %0d got %0d", $signed(e.pos[1]),
                           result.position_mid);
                    errors++;
                end
                if (result.position_slow !== e.pos[2])
                begin
                    $error("position_slow exp %0d got %0d", $signed(e.pos[2]),
                           result.position_slow);
                    errors++;
                end
                if (result.velocity_fast !== e.vel[0])
                begin
                    $error("velocity_fast exp %0d got %0d", $signed(e.vel[0]),
                           result.velocity_fast);
                    errors++;
                end
                if (result.velocity_mid !== e.vel[1])
                begin
                    $error("velocity_mid exp %0d got %0d", $signed(e.vel[1]),
                           result.velocity_mid);
                    errors++;
                end
                if (result.velocity_slow !== e.vel[2])
                begin
                    $error("velocity_slow exp %0d got %0d", $signed(e.vel[2]),
                           result.velocity_slow);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        // stall pattern: long open stretches, then stretches of random stalls
        if (!rst_n)
            result.ready <= 1'b0;
        else if (cycles % 3000 < 1200)
            result.ready <= 1'b1;
        else
            result.ready <= ($urandom_range(0, 3) != 0) && !hold_off;
    end

    task automatic write_reg(euvf_pkg::reg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        if (idx <= euvf_pkg::REG_POS_RETAIN_SLOW)
            pos_retain[idx] = value[15:0];
        else if (idx <= euvf_pkg::REG_VEL_RETAIN_SLOW)
            vel_retain[idx - euvf_pkg::REG_VEL_RETAIN_FAST] = value[15:0];
        else
            tick_rate = value;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // sender burst model; valid stays high across back-to-back requests
    int burst_left;

    task automatic send_sample(logic [13:0] angle, logic [31:0] ts, bit typed,
                               logic [29:0] unw, logic [37:0] pos, logic [39:0] vel);
        sample_out_t e;
        int          gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 40);
            if (gap != 0)
            begin
                sample.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        sample.valid        <= 1'b1;
        sample.angle_sample <= angle;
        sample.timestamp    <= ts;
        @(posedge clk);
        while (!sample.ready)
            @(posedge clk);
        e = predict_sample(angle, ts);
        if (typed && (e.unw !== unw || e.pos[0] !== pos || e.vel[0] !== vel))
        begin
            $error("directed row: predictor unw %0d pos %0d vel %0d", $signed(e.unw),
                   $signed(e.pos[0]), $signed(e.vel[0]));
            errors++;
        end
        pending_results.push_back(e);
        sent++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic idle_sender();
        sample.valid <= 1'b0;
        burst_left = 0;
        @(negedge clk);
    endtask

    row_t directed [$];

    function automatic row_t mk(logic [13:0] a, logic [31:0] t);
        row_t r;
        r.angle = a;
        r.ts    = t;
        r.typed = 1'b0;
        return r;
    endfunction

    initial
    begin
        row_t         r;
        logic [13:0]  ang;
        logic [31:0]  ts;
        int           step;
        cycles = 0;
        errors = 0;
        sent = 0;
        taken = 0;
        burst_left = 0;
        hold_off = 1'b0;
        rst_n = 1'b0;
        sample.valid = 1'b0;
        sample.angle_sample = '0;
        sample.timestamp = '0;
        cfg.valid = 1'b0;
        cfg.index = euvf_pkg::REG_POS_RETAIN_FAST;
        cfg.data = '0;
        seeded_q = 1'b0;
        last_angle = '0;
        turns = 0;
        last_time = '0;
        last_unw = 0;
        for (int i = 0; i < 3; i++)
        begin
            pos_filt[i] = 0;
            vel_filt[i] = 0;
        end
        pos_retain = '{euvf_pkg::POS_RETAIN_FAST_RST, euvf_pkg::POS_RETAIN_MID_RST,
                       euvf_pkg::POS_RETAIN_SLOW_RST};
        vel_retain = '{euvf_pkg::VEL_RETAIN_FAST_RST, euvf_pkg::VEL_RETAIN_MID_RST,
                       euvf_pkg::VEL_RETAIN_SLOW_RST};
        tick_rate = euvf_pkg::TPS_RST;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // first sample seeds all filters with angle * 256 and zero velocity
        r = mk(14'h3fff, 32'hffff_fff0);
        r.typed = 1'b1;
        r.unw = 30'd16383;
        r.pos = 38'd16383 * 256;
        r.vel = '0;
        directed.push_back(r);
        directed.push_back(mk(14'h3fff, 32'hffff_fff0)); // zero elapsed time
        directed.push_back(mk(14'd5, 32'h0000_0010));     // wrap up, timestamp wraps
        directed.push_back(mk(14'h3ff0, 32'h0000_0011));  // wrap down
        directed.push_back(mk(14'h3ff0 - 14'd8000, 32'h0000_0100)); // exactly threshold
        directed.push_back(mk(14'h3ff0, 32'h0000_0101));
        directed.push_back(mk(14'd0, 32'h0000_0102));
        directed.push_back(mk(14'd8001, 32'h8000_0000));
        directed.push_back(mk(14'd0, 32'h8000_0001));
        directed.push_back(mk(14'h2aaa, 32'h5555_5555));
        directed.push_back(mk(14'h1555, 32'haaaa_aaaa));
        foreach (directed[i])
            send_sample(directed[i].angle, directed[i].ts, directed[i].typed,
                        directed[i].unw, directed[i].pos, directed[i].vel);
        idle_sender();
        wait_drained();

        // extreme gains and rates: huge velocity saturates, zero gain follows input
        write_reg(euvf_pkg::REG_TICKS_PER_SEC, 32'hffff_ffff);
        write_reg(euvf_pkg::REG_POS_RETAIN_FAST, 16'h0000);
        write_reg(euvf_pkg::REG_POS_RETAIN_MID, 16'hffff);
        write_reg(euvf_pkg::REG_POS_RETAIN_SLOW, 16'h8000);
        write_reg(euvf_pkg::REG_VEL_RETAIN_FAST, 16'h0000);
        write_reg(euvf_pkg::REG_VEL_RETAIN_MID, 16'hffff);
        write_reg(euvf_pkg::REG_VEL_RETAIN_SLOW, 16'h0001);
        ts = 32'h1000;
        for (int i = 0; i < 6; i++)
        begin
            ang = (i % 2) ? 14'h3fff : 14'd0;
            ts = ts + 1;
            send_sample(ang, ts, 1'b0, '0, '0, '0);
        end
        idle_sender();
        wait_drained();
        write_reg(euvf_pkg::REG_TICKS_PER_SEC, 32'd1);

        // random phases, each after the first with fresh settings; mostly smooth motion with wraps
        ang = 14'd100;
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase > 0)
            begin
                idle_sender();
                wait_drained();
                for (int k = 0; k < 6; k++)
                    write_reg(euvf_pkg::reg_idx_t'(k), $urandom_range(0, 65535));
                case (phase % 3)
                    0: write_reg(euvf_pkg::REG_TICKS_PER_SEC, $urandom());
                    1: write_reg(euvf_pkg::REG_TICKS_PER_SEC, $urandom_range(1, 2000000));
                    default: write_reg(euvf_pkg::REG_TICKS_PER_SEC, euvf_pkg::TPS_RST);
                endcase
            end
            step = $urandom_range(0, 3000);
            for (int n = 0; n < 150; n++)
            begin
                case ($urandom_range(0, 9))
                    0: ang = 14'($urandom());
                    1: ts = $urandom();
                    default:
                    begin
                        if ($urandom_range(0, 1))
                            ang = ang + 14'(step);
                        else
                            ang = ang - 14'(step);
                        ts = ts + $urandom_range(0, 5000);
                    end
                endcase
                send_sample(ang, ts, 1'b0, '0, '0, '0);
            end
        end

        // one-way spin forward then backward, a wrap every few samples
        idle_sender();
        wait_drained();
        write_reg(euvf_pkg::REG_TICKS_PER_SEC, euvf_pkg::TPS_RST);
        for (int n = 0; n < 40; n++)
        begin
            ang = (n < 25) ? ang + 14'd7000 : ang - 14'd7000;
            ts = ts + 32'd100;
            send_sample(ang, ts, 1'b0, '0, '0, '0);
        end
        idle_sender();
        wait_drained();
        $display("checked %0d results over %0d samples, with reset, extreme and random settings",
                 taken, sent);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
